### hw/rtl/gram_schmidt_color_projection_top_macros.svh
// Assertion macros used by the color projection controller
`ifndef GRAM_SCHMIDT_COLOR_PROJECTION_TOP_MACROS_SVH
`define GRAM_SCHMIDT_COLOR_PROJECTION_TOP_MACROS_SVH

// same-cycle implication
`define GSCP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GSCP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/gscp_pkg.sv
// Types, constants and microcode for the color projection block
package gscp_pkg;

   localparam int COLOR_W   = 24;
   localparam int CH_W      = 8;
   localparam int W_W       = 18;
   localparam int OUT_W     = 28;
   localparam int ACC_W     = 48;
   localparam int PROD_W    = 46;
   localparam int DEN_W     = 36;
   localparam int OPND_W    = 28;
   localparam int OPNDB_W   = 18;
   localparam int PC_W      = 5;
   localparam int CSR_IDX_W = 2;
   localparam int WSEL_W    = 2;
   localparam int PP_W      = 27;
   localparam int SUM_W     = 29;

   localparam logic [PC_W-1:0]     PC_WEIGHT = 5'd24;
   localparam logic [PC_W-1:0]     PC_LAST   = 5'd25;
   localparam logic [WSEL_W-1:0]   WSEL_LAST = 2'd2;

   localparam logic signed [W_W-1:0]   WEIGHT_MAX = 18'sd131071;
   localparam logic signed [W_W-1:0]   WEIGHT_MIN = -18'sd131072;
   localparam logic signed [OUT_W-1:0] OUT_MAX    = 28'sd134217727;
   localparam logic signed [OUT_W-1:0] OUT_MIN    = -28'sd134217728;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COLOR_ONE   = 2'd0,
      REG_COLOR_TWO   = 2'd1,
      REG_COLOR_THREE = 2'd2
   } reg_idx_type;

   typedef enum logic [3:0] {
      SRC_A0, SRC_A1, SRC_A2,
      SRC_B0, SRC_B1, SRC_B2,
      SRC_C0, SRC_C1, SRC_C2,
      SRC_N0, SRC_N1, SRC_N2,
      SRC_X,  SRC_Y,  SRC_Z,  SRC_W
   } src_type;

   typedef enum logic [1:0] {
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_N0, DST_N1, DST_N2, DST_NN,
      DST_CN, DST_AA, DST_BB, DST_CA, DST_CB, DST_NUM
   } dst_type;

   typedef struct packed {
      src_type    src_a;
      src_type    src_b;
      acc_op_type op;
      dst_type    dst;
   } uop_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_DIV_GO,
      ST_DIV,
      ST_STORE
   } state_type;

   typedef struct packed {
      logic                 mul_en;
      logic                 acc_en;
      uop_type              uop;
      logic [WSEL_W-1:0]    wsel;
      logic                 div_start;
      logic                 w_store;
      logic                 pipe_en;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
   } status_type;

   function automatic uop_type ucode(input logic [PC_W-1:0] pc);
      uop_type u;
      case (pc)
         5'd0:  u = '{SRC_A1, SRC_B2, ACC_LOAD, DST_NONE};
         5'd1:  u = '{SRC_A2, SRC_B1, ACC_SUB,  DST_N0};
         5'd2:  u = '{SRC_A2, SRC_B0, ACC_LOAD, DST_NONE};
         5'd3:  u = '{SRC_A0, SRC_B2, ACC_SUB,  DST_N1};
         5'd4:  u = '{SRC_A0, SRC_B1, ACC_LOAD, DST_NONE};
         5'd5:  u = '{SRC_A1, SRC_B0, ACC_SUB,  DST_N2};
         5'd6:  u = '{SRC_N0, SRC_N0, ACC_LOAD, DST_NONE};
         5'd7:  u = '{SRC_N1, SRC_N1, ACC_ADD,  DST_NONE};
         5'd8:  u = '{SRC_N2, SRC_N2, ACC_ADD,  DST_NN};
         5'd9:  u = '{SRC_C0, SRC_N0, ACC_LOAD, DST_NONE};
         5'd10: u = '{SRC_C1, SRC_N1, ACC_ADD,  DST_NONE};
         5'd11: u = '{SRC_C2, SRC_N2, ACC_ADD,  DST_CN};
         5'd12: u = '{SRC_A0, SRC_A0, ACC_LOAD, DST_NONE};
         5'd13: u = '{SRC_A1, SRC_A1, ACC_ADD,  DST_NONE};
         5'd14: u = '{SRC_A2, SRC_A2, ACC_ADD,  DST_AA};
         5'd15: u = '{SRC_B0, SRC_B0, ACC_LOAD, DST_NONE};
         5'd16: u = '{SRC_B1, SRC_B1, ACC_ADD,  DST_NONE};
         5'd17: u = '{SRC_B2, SRC_B2, ACC_ADD,  DST_BB};
         5'd18: u = '{SRC_C0, SRC_A0, ACC_LOAD, DST_NONE};
         5'd19: u = '{SRC_C1, SRC_A1, ACC_ADD,  DST_NONE};
         5'd20: u = '{SRC_C2, SRC_A2, ACC_ADD,  DST_CA};
         5'd21: u = '{SRC_C0, SRC_B0, ACC_LOAD, DST_NONE};
         5'd22: u = '{SRC_C1, SRC_B1, ACC_ADD,  DST_NONE};
         5'd23: u = '{SRC_C2, SRC_B2, ACC_ADD,  DST_CB};
         5'd24: u = '{SRC_X,  SRC_Y,  ACC_LOAD, DST_NONE};
         5'd25: u = '{SRC_Z,  SRC_W,  ACC_SUB,  DST_NUM};
         default: u = '{SRC_A0, SRC_A0, ACC_LOAD, DST_NONE};
      endcase
      return u;
   endfunction

endpackage

### hw/rtl/gscp_if.sv
// Pixel and result channel interfaces
interface gscp_req_if;
   logic                         valid;
   logic                         ready;
   logic [gscp_pkg::CH_W-1:0]    pix_blue;
   logic [gscp_pkg::CH_W-1:0]    pix_green;
   logic [gscp_pkg::CH_W-1:0]    pix_red;
   modport source (output valid, pix_blue, pix_green, pix_red, input ready);
   modport sink   (input valid, pix_blue, pix_green, pix_red, output ready);
endinterface

interface gscp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [gscp_pkg::OUT_W-1:0]  projection_value;
   modport source (output valid, projection_value, input ready);
   modport sink   (input valid, projection_value, output ready);
endinterface

### hw/rtl/gscp_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero
module gscp_div #(
   parameter int FRAC_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [gscp_pkg::ACC_W-1:0]     num,
   input  logic [gscp_pkg::DEN_W-1:0]            den,
   output logic                                  busy,
   output logic                                  neg,
   output logic [gscp_pkg::ACC_W+FRAC_BITS-1:0]  quo
);
   localparam int NUM_W = gscp_pkg::ACC_W + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W);

   logic                          busy_ff, busy_in;
   logic                          neg_ff, neg_in;
   logic [NUM_W-1:0]              quo_ff, quo_in;
   logic [gscp_pkg::DEN_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [gscp_pkg::ACC_W-1:0]    mag;
   logic [gscp_pkg::DEN_W:0]      trial;
   logic                          fits;

   always_comb begin
      mag   = num[gscp_pkg::ACC_W-1] ? gscp_pkg::ACC_W'(-num) : gscp_pkg::ACC_W'(num);
      trial = {rem_ff, quo_ff[NUM_W-1]};
      fits  = trial >= {1'b0, den};
      busy_in = busy_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = num[gscp_pkg::ACC_W-1];
         quo_in  = {mag, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         cnt_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? gscp_pkg::DEN_W'(trial - {1'b0, den})
                       : trial[gscp_pkg::DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign busy = busy_ff;
   assign neg  = neg_ff;
   assign quo  = quo_ff;
endmodule

### hw/rtl/gscp_dp.sv
// Datapath: color registers, shared multiply-accumulate, weights, pixel pipeline
module gscp_dp #(
   parameter int FRAC_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gscp_pkg::cmd_type                     cmd,
   output gscp_pkg::status_type                  status,
   input  logic                                  csr_write,
   input  logic [gscp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gscp_pkg::COLOR_W-1:0]          csr_wdata,
   input  logic [gscp_pkg::CH_W-1:0]             pix_blue,
   input  logic [gscp_pkg::CH_W-1:0]             pix_green,
   input  logic [gscp_pkg::CH_W-1:0]             pix_red,
   output logic signed [gscp_pkg::OUT_W-1:0]     projection_value
);
   localparam int NUM_W = gscp_pkg::ACC_W + FRAC_BITS;

   logic [gscp_pkg::COLOR_W-1:0]             col_one_ff, col_two_ff, col_three_ff;
   logic [gscp_pkg::CH_W-1:0]                a_ch [3];
   logic [gscp_pkg::CH_W-1:0]                b_ch [3];
   logic [gscp_pkg::CH_W-1:0]                c_ch [3];
   logic signed [gscp_pkg::OPNDB_W-1:0]      n_ff [3];
   logic signed [gscp_pkg::DEN_W-1:0]        nn_ff;
   logic signed [gscp_pkg::OPND_W-1:0]       cn_ff;
   logic signed [18:0]                       aa_ff, bb_ff, ca_ff, cb_ff;
   logic signed [gscp_pkg::ACC_W-1:0]        num_ff;
   logic signed [gscp_pkg::ACC_W-1:0]        acc_ff, acc_in;
   logic signed [gscp_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic signed [gscp_pkg::W_W-1:0]          w_ff [3];
   logic signed [gscp_pkg::W_W-1:0]          w_sat;
   logic signed [gscp_pkg::OPND_W-1:0]       sv [16];
   logic signed [gscp_pkg::OPND_W-1:0]       opnd_a;
   logic signed [gscp_pkg::OPNDB_W-1:0]      opnd_b;
   logic                                     n_nz, a_nz, b_nz;
   logic [gscp_pkg::DEN_W-1:0]               den;
   logic                                     div_neg;
   logic [NUM_W-1:0]                         div_quo;
   logic                                     div_busy;
   logic signed [gscp_pkg::PP_W-1:0]         pp_ff [3];
   logic signed [gscp_pkg::PP_W-1:0]         pp_in [3];
   logic signed [gscp_pkg::SUM_W-1:0]        sum;
   logic signed [gscp_pkg::OUT_W-1:0]        out_ff, out_in;

   function automatic logic signed [gscp_pkg::OPND_W-1:0] ext8(
      input logic [gscp_pkg::CH_W-1:0] v);
      return {{(gscp_pkg::OPND_W - gscp_pkg::CH_W){1'b0}}, v};
   endfunction

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_ch[i] = col_one_ff[8*i +: 8];
         b_ch[i] = col_two_ff[8*i +: 8];
         c_ch[i] = col_three_ff[8*i +: 8];
      end
      n_nz = (n_ff[0] != '0) || (n_ff[1] != '0) || (n_ff[2] != '0);
      a_nz = aa_ff != '0;
      b_nz = bb_ff != '0;
      if (n_nz) begin
         den = gscp_pkg::DEN_W'(nn_ff);
      end else if (a_nz) begin
         den = gscp_pkg::DEN_W'(aa_ff);
      end else if (b_nz) begin
         den = gscp_pkg::DEN_W'(bb_ff);
      end else begin
         den = gscp_pkg::DEN_W'(1);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sv[i]     = ext8(a_ch[i]);
         sv[3 + i] = ext8(b_ch[i]);
         sv[6 + i] = ext8(c_ch[i]);
         sv[9 + i] = gscp_pkg::OPND_W'(n_ff[i]);
      end
      if (n_nz) begin
         sv[gscp_pkg::SRC_X] = cn_ff;
      end else if (a_nz) begin
         sv[gscp_pkg::SRC_X] = gscp_pkg::OPND_W'(aa_ff);
      end else if (b_nz) begin
         sv[gscp_pkg::SRC_X] = gscp_pkg::OPND_W'(bb_ff);
      end else begin
         sv[gscp_pkg::SRC_X] = gscp_pkg::OPND_W'(1);
      end
      sv[gscp_pkg::SRC_Y] = n_nz ? gscp_pkg::OPND_W'(n_ff[cmd.wsel]) : ext8(c_ch[cmd.wsel]);
      if (n_nz) begin
         sv[gscp_pkg::SRC_Z] = '0;
      end else if (a_nz) begin
         sv[gscp_pkg::SRC_Z] = gscp_pkg::OPND_W'(ca_ff);
      end else if (b_nz) begin
         sv[gscp_pkg::SRC_Z] = gscp_pkg::OPND_W'(cb_ff);
      end else begin
         sv[gscp_pkg::SRC_Z] = '0;
      end
      sv[gscp_pkg::SRC_W] = a_nz ? ext8(a_ch[cmd.wsel]) : ext8(b_ch[cmd.wsel]);
      opnd_a  = sv[cmd.uop.src_a];
      opnd_b  = $signed(sv[cmd.uop.src_b][gscp_pkg::OPNDB_W-1:0]);
      prod_in = gscp_pkg::PROD_W'(opnd_a) * gscp_pkg::PROD_W'(opnd_b);
      case (cmd.uop.op)
         gscp_pkg::ACC_LOAD: acc_in = gscp_pkg::ACC_W'(prod_ff);
         gscp_pkg::ACC_ADD:  acc_in = acc_ff + gscp_pkg::ACC_W'(prod_ff);
         gscp_pkg::ACC_SUB:  acc_in = acc_ff - gscp_pkg::ACC_W'(prod_ff);
         default:            acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_one_ff   <= '0;
         col_two_ff   <= '0;
         col_three_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            gscp_pkg::REG_COLOR_ONE:   col_one_ff   <= csr_wdata;
            gscp_pkg::REG_COLOR_TWO:   col_two_ff   <= csr_wdata;
            gscp_pkg::REG_COLOR_THREE: col_three_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.acc_en) begin
         acc_ff <= acc_in;
         case (cmd.uop.dst)
            gscp_pkg::DST_N0:  n_ff[0] <= acc_in[gscp_pkg::OPNDB_W-1:0];
            gscp_pkg::DST_N1:  n_ff[1] <= acc_in[gscp_pkg::OPNDB_W-1:0];
            gscp_pkg::DST_N2:  n_ff[2] <= acc_in[gscp_pkg::OPNDB_W-1:0];
            gscp_pkg::DST_NN:  nn_ff   <= acc_in[gscp_pkg::DEN_W-1:0];
            gscp_pkg::DST_CN:  cn_ff   <= acc_in[gscp_pkg::OPND_W-1:0];
            gscp_pkg::DST_AA:  aa_ff   <= acc_in[18:0];
            gscp_pkg::DST_BB:  bb_ff   <= acc_in[18:0];
            gscp_pkg::DST_CA:  ca_ff   <= acc_in[18:0];
            gscp_pkg::DST_CB:  cb_ff   <= acc_in[18:0];
            gscp_pkg::DST_NUM: num_ff  <= acc_in;
            default: ;
         endcase
      end
   end

   gscp_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_ff),
      .den   (den),
      .busy  (div_busy),
      .neg   (div_neg),
      .quo   (div_quo)
   );

   assign status.div_busy = div_busy;

   always_comb begin
      if (div_neg) begin
         if (div_quo > NUM_W'(131072)) begin
            w_sat = gscp_pkg::WEIGHT_MIN;
         end else begin
            w_sat = -$signed(div_quo[gscp_pkg::W_W-1:0]);
         end
      end else begin
         if (div_quo > NUM_W'(131071)) begin
            w_sat = gscp_pkg::WEIGHT_MAX;
         end else begin
            w_sat = $signed(div_quo[gscp_pkg::W_W-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.w_store) begin
         w_ff[cmd.wsel] <= w_sat;
      end
   end

   always_comb begin
      pp_in[0] = gscp_pkg::PP_W'($signed({1'b0, pix_blue}))  * gscp_pkg::PP_W'(w_ff[0]);
      pp_in[1] = gscp_pkg::PP_W'($signed({1'b0, pix_green})) * gscp_pkg::PP_W'(w_ff[1]);
      pp_in[2] = gscp_pkg::PP_W'($signed({1'b0, pix_red}))   * gscp_pkg::PP_W'(w_ff[2]);
      sum = gscp_pkg::SUM_W'(pp_ff[0]) + gscp_pkg::SUM_W'(pp_ff[1])
          + gscp_pkg::SUM_W'(pp_ff[2]);
      if (sum > gscp_pkg::SUM_W'(gscp_pkg::OUT_MAX)) begin
         out_in = gscp_pkg::OUT_MAX;
      end else if (sum < gscp_pkg::SUM_W'(gscp_pkg::OUT_MIN)) begin
         out_in = gscp_pkg::OUT_MIN;
      end else begin
         out_in = sum[gscp_pkg::OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pipe_en) begin
         pp_ff  <= pp_in;
         out_ff <= out_in;
      end
   end

   assign projection_value = out_ff;
endmodule

### hw/rtl/gscp_ctrl.sv
// Controller: weight computation sequencer and pixel pipeline handshake
`include "gram_schmidt_color_projection_top_macros.svh"
module gscp_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [gscp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic                                req_valid,
   output logic                                req_ready,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output gscp_pkg::cmd_type                   cmd,
   input  gscp_pkg::status_type                status
);
   gscp_pkg::state_type                 state_ff, state_in;
   logic [gscp_pkg::PC_W-1:0]           pc_ff, pc_in;
   logic [gscp_pkg::WSEL_W-1:0]         wi_ff, wi_in;
   logic                                wr_ff, wr_in;
   logic                                s1_valid_ff, s1_valid_in;
   logic                                out_valid_ff, out_valid_in;
   logic                                cfg_hit;
   logic                                pipe_en;
   logic                                accept;

   assign cfg_hit = csr_write && (csr_index inside {gscp_pkg::REG_COLOR_ONE,
                                                    gscp_pkg::REG_COLOR_TWO,
                                                    gscp_pkg::REG_COLOR_THREE});

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gscp_pkg::ST_IDLE:   if (req_valid && !wr_ff) state_in = gscp_pkg::ST_MUL;
         gscp_pkg::ST_MUL:    state_in = gscp_pkg::ST_ACC;
         gscp_pkg::ST_ACC:    state_in = (pc_ff == gscp_pkg::PC_LAST) ? gscp_pkg::ST_DIV_GO
                                                                      : gscp_pkg::ST_MUL;
         gscp_pkg::ST_DIV_GO: state_in = gscp_pkg::ST_DIV;
         gscp_pkg::ST_DIV:    if (!status.div_busy) state_in = gscp_pkg::ST_STORE;
         gscp_pkg::ST_STORE:  state_in = (wi_ff == gscp_pkg::WSEL_LAST) ? gscp_pkg::ST_IDLE
                                                                        : gscp_pkg::ST_MUL;
         default:             state_in = gscp_pkg::ST_IDLE;
      endcase
      if (cfg_hit) begin
         state_in = gscp_pkg::ST_IDLE;
      end
   end

   always_comb begin
      pc_in = pc_ff;
      wi_in = wi_ff;
      wr_in = wr_ff;
      case (state_ff)
         gscp_pkg::ST_IDLE: begin
            pc_in = '0;
            wi_in = '0;
         end
         gscp_pkg::ST_ACC: begin
            if (pc_ff != gscp_pkg::PC_LAST) pc_in = pc_ff + 1'b1;
         end
         gscp_pkg::ST_STORE: begin
            pc_in = gscp_pkg::PC_WEIGHT;
            wi_in = wi_ff + 1'b1;
            if (wi_ff == gscp_pkg::WSEL_LAST) wr_in = 1'b1;
         end
         default: ;
      endcase
      if (cfg_hit) begin
         pc_in = '0;
         wi_in = '0;
         wr_in = 1'b0;
      end
   end

   always_comb begin
      pipe_en      = !out_valid_ff || rsp_ready;
      req_ready    = wr_ff && pipe_en;
      accept       = req_valid && req_ready;
      s1_valid_in  = pipe_en ? accept : s1_valid_ff;
      out_valid_in = pipe_en ? s1_valid_ff : out_valid_ff;
      rsp_valid    = out_valid_ff;
      cmd           = '0;
      cmd.mul_en    = state_ff == gscp_pkg::ST_MUL;
      cmd.acc_en    = state_ff == gscp_pkg::ST_ACC;
      cmd.uop       = gscp_pkg::ucode(pc_ff);
      cmd.wsel      = wi_ff;
      cmd.div_start = state_ff == gscp_pkg::ST_DIV_GO;
      cmd.w_store   = state_ff == gscp_pkg::ST_STORE;
      cmd.pipe_en   = pipe_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gscp_pkg::ST_IDLE;
         pc_ff        <= '0;
         wi_ff        <= '0;
         wr_ff        <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         wi_ff        <= wi_in;
         wr_ff        <= wr_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   `GSCP_ASSERT_IMP(a_ready_needs_weights, clock, reset, req_ready, wr_ff, "ready without weights")
   `GSCP_ASSERT_NXT(a_cfg_clears_weights, clock, reset, cfg_hit, !wr_ff, "config kept weights")
   `GSCP_ASSERT_IMP(a_store_after_div, clock, reset, state_ff == gscp_pkg::ST_STORE, !status.div_busy, "store while dividing")
   `GSCP_ASSERT_NXT(a_div_go_busy, clock, reset, state_ff == gscp_pkg::ST_DIV_GO, status.div_busy, "divider did not start")
   `GSCP_ASSERT_IMP(a_weights_idle, clock, reset, wr_ff, state_ff == gscp_pkg::ST_IDLE, "sequencer runs with weights")
endmodule

### hw/rtl/gram_schmidt_color_projection_top.sv
// Result path: pixel products are registered, then the saturated sum is.
// Throughput: one item per cycle with weights held, unless rsp.ready stalls.
// First item after reset or a color write waits for the weight vector, whose
// computation starts when a request arrives: 30 multiply-accumulate steps,
// each a multiply then an accumulate state, and per weight a divide and store.
// Reset (synchronous) clears colors, handshake state and the weight-ready flag.
module gram_schmidt_color_projection_top #(
   parameter int FRAC_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   gscp_req_if.sink                            req,
   gscp_rsp_if.source                          rsp,
   input  logic                                csr_write,
   input  logic [gscp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gscp_pkg::COLOR_W-1:0]        csr_wdata
);
   gscp_pkg::cmd_type     cmd;
   gscp_pkg::status_type  status;

   gscp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .status    (status)
   );

   gscp_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .pix_blue         (req.pix_blue),
      .pix_green        (req.pix_green),
      .pix_red          (req.pix_red),
      .projection_value (rsp.projection_value)
   );
endmodule
